// File: hdl/fmsam_pkg.sv
// Shared constants, register indexes and configuration type of the FM stereo audio matrix.
package fmsam_pkg;

   localparam int SAMPLE_WIDTH_DEF     = 16;
   localparam int DEEMPH_FRAC_BITS_DEF = 8;
   localparam int QUEUE_DEPTH          = 2;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PANO_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PANORAMA_GAIN = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_SELECT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEEMPH_ALPHA  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLUME_GAIN   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BALANCE       = 3'd5;

   // Output selection codes.
   localparam logic [2:0] SEL_STEREO    = 3'd0;
   localparam logic [2:0] SEL_SWAPPED   = 3'd1;
   localparam logic [2:0] SEL_LEFT      = 3'd2;
   localparam logic [2:0] SEL_RIGHT     = 3'd3;
   localparam logic [2:0] SEL_SUM       = 3'd4;
   localparam logic [2:0] SEL_DIFF      = 3'd5;
   localparam logic [2:0] SEL_DIFF_TEST = 3'd6;

   // Volume and balance scaling: divide by 4096 * 100 = 2^14 * 25, rounded.
   localparam int GAIN_ROUND = 204800;
   localparam int GAIN_SHIFT = 14;
   localparam int GAIN_DIV   = 25;
   localparam int PCT_FULL   = 100;

   typedef struct packed {
      logic               pano_enable;
      logic [9:0]         panorama_gain;
      logic [2:0]         output_select;
      logic [15:0]        deemph_alpha;
      logic [15:0]        volume_gain;
      logic signed [7:0]  balance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pano_enable:   1'b0,
      panorama_gain: 10'd256,
      output_select: SEL_STEREO,
      deemph_alpha:  16'd6827,
      volume_gain:   16'd2048,
      balance:       8'sd0
   };

endpackage

// File: hdl/fm_stereo_audio_matrix_unit.sv
// The back end takes a new item only when it is back in idle, after its eight-step
// sequence (dequeue, filter multiply, state update, rounding, gain multiply
// and a three-step rounded divide by 409600) over two parallel lanes; its last
// step waits while the output register holds a pair that has not been taken.
// Synchronous reset restores register defaults, clears both filter states and
// empties the queue.
module fm_stereo_audio_matrix_unit #(
   parameter int SAMPLE_WIDTH     = fmsam_pkg::SAMPLE_WIDTH_DEF,
   parameter int DEEMPH_FRAC_BITS = fmsam_pkg::DEEMPH_FRAC_BITS_DEF,
   localparam int TDATA_WIDTH     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [TDATA_WIDTH-1:0]                 req_tdata,   // sum_sample, diff_sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [TDATA_WIDTH-1:0]                 rsp_tdata,   // left_out, right_out
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fmsam_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fmsam_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import fmsam_pkg::*;

   localparam int SW = SAMPLE_WIDTH;

   cfg_type                 cfg_ff;
   logic                    push;
   logic [2*SW-1:0]         push_data;
   logic                    full;
   logic                    pop;
   logic [2*SW-1:0]         head_data;
   logic                    empty;
   logic signed [SW-1:0]    out_left;
   logic signed [SW-1:0]    out_right;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PANO_ENABLE:   cfg_ff.pano_enable   <= csr_data[0];
            CSR_PANORAMA_GAIN: cfg_ff.panorama_gain <= csr_data[9:0];
            CSR_OUTPUT_SELECT: cfg_ff.output_select <= csr_data[2:0];
            CSR_DEEMPH_ALPHA:  cfg_ff.deemph_alpha  <= csr_data;
            CSR_VOLUME_GAIN:   cfg_ff.volume_gain   <= csr_data;
            CSR_BALANCE:       cfg_ff.balance       <= $signed(csr_data[7:0]);
            default: ;
         endcase
      end
   end

   fmsam_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sum    ($signed(req_tdata[SW-1:0])),
      .in_diff   ($signed(req_tdata[2*SW-1:SW])),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   fmsam_fifo #(
      .WIDTH (2 * SW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head_data (head_data),
      .empty     (empty)
   );

   fmsam_back #(
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .DEEMPH_FRAC_BITS (DEEMPH_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .empty     (empty),
      .head_data (head_data),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_left  (out_left),
      .out_right (out_right)
   );

   assign rsp_tdata = TDATA_WIDTH'({out_right, out_left});

endmodule

// File: hdl/fmsam_fifo.sv
// Small register queue between the matrix front end and the filter and gain back end.
module fmsam_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// File: hdl/fmsam_front.sv
// Front end: takes a sum and difference sample, applies panorama weight, matrix and selection.
module fmsam_front #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fmsam_pkg::cfg_type        cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sum,
   input  logic signed [SAMPLE_WIDTH-1:0] in_diff,
   output logic                      push,
   output logic [2*SAMPLE_WIDTH-1:0] push_data,
   input  logic                      full
);
   import fmsam_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int PW = SW + 11;

   localparam logic signed [SW+2:0] D_MAX = (SW+3)'((longint'(1) << (SW - 1)) - 1);
   localparam logic signed [SW+2:0] D_MIN = (SW+3)'(-(longint'(1) << (SW - 1)));
   localparam logic signed [SW:0]   M_MAX = (SW+1)'((longint'(1) << (SW - 1)) - 1);
   localparam logic signed [SW:0]   M_MIN = (SW+1)'(-(longint'(1) << (SW - 1)));

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_type;

   fstate_type              state_ff;
   logic signed [SW-1:0]    sum_ff;
   logic signed [SW-1:0]    diff_ff;
   logic signed [PW-1:0]    prod_ff;

   logic signed [PW-1:0]    prod_in;
   logic signed [PW-1:0]    prod_rnd;
   logic signed [SW+2:0]    d_wide;
   logic signed [SW-1:0]    d_val;
   logic signed [SW:0]      l_wide;
   logic signed [SW:0]      r_wide;
   logic signed [SW-1:0]    l_val;
   logic signed [SW-1:0]    r_val;
   logic signed [SW-1:0]    a_val;
   logic signed [SW-1:0]    b_val;

   assign in_ready = (state_ff == F_IDLE);
   assign push     = (state_ff == F_PUSH);
   assign prod_in  = PW'(diff_ff) * PW'($signed({1'b0, cfg.panorama_gain}));

   always_comb begin
      prod_rnd = prod_ff + PW'(128);
      d_wide   = (SW+3)'(prod_rnd >>> 8);
      if (!cfg.pano_enable) begin
         d_val = diff_ff;
      end else if (d_wide > D_MAX) begin
         d_val = SW'(D_MAX);
      end else if (d_wide < D_MIN) begin
         d_val = SW'(D_MIN);
      end else begin
         d_val = SW'(d_wide);
      end

      l_wide = (SW+1)'(sum_ff) + (SW+1)'(d_val);
      r_wide = (SW+1)'(sum_ff) - (SW+1)'(d_val);
      l_val  = (l_wide > M_MAX) ? SW'(M_MAX) : (l_wide < M_MIN) ? SW'(M_MIN) : SW'(l_wide);
      r_val  = (r_wide > M_MAX) ? SW'(M_MAX) : (r_wide < M_MIN) ? SW'(M_MIN) : SW'(r_wide);

      unique case (cfg.output_select)
         SEL_SWAPPED: begin
            a_val = r_val;
            b_val = l_val;
         end
         SEL_LEFT: begin
            a_val = l_val;
            b_val = l_val;
         end
         SEL_RIGHT: begin
            a_val = r_val;
            b_val = r_val;
         end
         SEL_SUM: begin
            a_val = sum_ff;
            b_val = sum_ff;
         end
         SEL_DIFF, SEL_DIFF_TEST: begin
            a_val = d_val;
            b_val = d_val;
         end
         default: begin
            // Stereo, and the unused code behaves the same.
            a_val = l_val;
            b_val = r_val;
         end
      endcase
   end

   assign push_data = {b_val, a_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (in_valid) begin
                  sum_ff   <= in_sum;
                  diff_ff  <= in_diff;
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// File: hdl/fmsam_back.sv
// Back end: two-lane de-emphasis filter, volume and balance scaling, output register.
module fmsam_back #(
   parameter int SAMPLE_WIDTH     = 16,
   parameter int DEEMPH_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fmsam_pkg::cfg_type            cfg,
   input  logic                          empty,
   input  logic [2*SAMPLE_WIDTH-1:0]     head_data,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_WIDTH-1:0] out_left,
   output logic signed [SAMPLE_WIDTH-1:0] out_right
);
   import fmsam_pkg::*;

   localparam int SW  = SAMPLE_WIDTH;
   localparam int FB  = DEEMPH_FRAC_BITS;
   localparam int ST  = SW + FB;
   localparam int EW  = ST + 1;
   localparam int PE  = EW + 17;
   localparam int PG  = SW + 24;
   localparam int Q1W = PG - GAIN_SHIFT;
   localparam int NB  = SW + 5;
   localparam int K   = NB + 5;
   localparam int RW  = K - 4;
   localparam int PRW = NB + RW;

   localparam logic signed [ST:0]    HALF   = (ST+1)'((1 << FB) >> 1);
   localparam logic signed [ST:0]    Y_MAX  = (ST+1)'((longint'(1) << (SW - 1)) - 1);
   localparam logic signed [ST:0]    Y_MIN  = (ST+1)'(-(longint'(1) << (SW - 1)));
   localparam logic signed [Q1W-1:0] CL_HI  =
      Q1W'((longint'(GAIN_DIV) << (SW - 1)) - 1);
   localparam logic signed [Q1W-1:0] CL_LO  = Q1W'(-(longint'(GAIN_DIV) << (SW - 1)));
   localparam logic [RW-1:0]         RECIP  = RW'((longint'(1) << K) / GAIN_DIV);

   typedef enum logic [2:0] {
      B_IDLE, B_MUL, B_UPD, B_Y, B_MULG, B_DIV1, B_DIV2, B_DIV3
   } bstate_type;

   bstate_type              state_ff;
   logic signed [ST-1:0]    st_ff  [2];
   logic signed [EW-1:0]    e_ff   [2];
   logic signed [PE-1:0]    pe_ff  [2];
   logic [22:0]             vp_ff  [2];
   logic signed [SW-1:0]    y_ff   [2];
   logic signed [PG-1:0]    pg_ff  [2];
   logic [NB-1:0]           u_ff   [2];
   logic [PRW-1:0]          pr_ff  [2];
   logic                    out_valid_ff;
   logic signed [SW-1:0]    out_ff [2];

   logic signed [SW-1:0]    x      [2];
   logic [6:0]              pct    [2];
   logic signed [EW-1:0]    e_in   [2];
   logic signed [PE-1:0]    pe_in  [2];
   logic [22:0]             vp_in  [2];
   logic signed [ST-1:0]    st_in  [2];
   logic signed [SW-1:0]    y_in   [2];
   logic signed [PG-1:0]    pg_in  [2];
   logic [NB-1:0]           u_in   [2];
   logic [PRW-1:0]          pr_in  [2];
   logic signed [SW-1:0]    out_in [2];
   logic                    out_valid_in;
   logic signed [7:0]       bal;
   logic                    out_free;

   assign out_free  = !out_valid_ff || out_ready;
   assign pop       = (state_ff == B_IDLE) && !empty;
   assign out_valid = out_valid_ff;
   assign out_left  = out_ff[0];
   assign out_right = out_ff[1];
   assign x[0]      = head_data[SW-1:0];
   assign x[1]      = head_data[2*SW-1:SW];

   // A new pair is loaded when the last step finds the output free; otherwise a
   // waiting pair stays until it is taken.
   assign out_valid_in = ((state_ff == B_DIV3) && out_free) || (out_valid_ff && !out_ready);

   // Balance beyond the percent range mutes the attenuated channel fully.
   always_comb begin
      if (cfg.balance > 8'sd100) begin
         bal = 8'sd100;
      end else if (cfg.balance < -8'sd100) begin
         bal = -8'sd100;
      end else begin
         bal = cfg.balance;
      end
      pct[0] = (bal > 8'sd0) ? 7'(8'sd100 - bal) : 7'(PCT_FULL);
      pct[1] = (bal < 8'sd0) ? 7'(8'sd100 + bal) : 7'(PCT_FULL);
   end

   always_comb begin
      logic signed [PE-1:0]  rnd;
      logic signed [ST:0]    t;
      logic signed [ST:0]    ts;
      logic signed [PG-1:0]  pgr;
      logic signed [Q1W-1:0] q1;
      logic signed [Q1W-1:0] q1c;
      logic [SW-1:0]         qe;
      logic [NB-1:0]         rem;
      logic [SW-1:0]         q;
      for (int i = 0; i < 2; i++) begin
         e_in[i]  = (EW'(x[i]) <<< FB) - EW'(st_ff[i]);
         pe_in[i] = PE'(e_ff[i]) * PE'($signed({1'b0, cfg.deemph_alpha}));
         vp_in[i] = 23'(cfg.volume_gain) * 23'(pct[i]);

         rnd      = pe_ff[i] + PE'(32768);
         st_in[i] = st_ff[i] + rnd[ST+15:16];

         t  = (ST+1)'(st_ff[i]) + HALF;
         ts = t >>> FB;
         if (ts > Y_MAX) begin
            y_in[i] = SW'(Y_MAX);
         end else if (ts < Y_MIN) begin
            y_in[i] = SW'(Y_MIN);
         end else begin
            y_in[i] = SW'(ts);
         end

         pg_in[i] = PG'(y_ff[i]) * PG'($signed({1'b0, vp_ff[i]}));

         // Divide by 2^14 first, clamp so that the divide by 25 lands in range,
         // then offset to a non-negative value for the reciprocal step.
         pgr = pg_ff[i] + PG'(GAIN_ROUND);
         q1  = Q1W'(pgr >>> GAIN_SHIFT);
         q1c = (q1 > CL_HI) ? CL_HI : (q1 < CL_LO) ? CL_LO : q1;
         u_in[i] = NB'(q1c - CL_LO);

         pr_in[i] = PRW'(u_ff[i]) * PRW'(RECIP);

         // The reciprocal estimate is at most one short of the true quotient.
         qe  = pr_ff[i][K +: SW];
         rem = u_ff[i] - NB'(qe) * NB'(GAIN_DIV);
         q   = qe + SW'(rem >= NB'(GAIN_DIV));
         out_in[i] = {~q[SW-1], q[SW-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            st_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  e_ff     <= e_in;
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               pe_ff    <= pe_in;
               vp_ff    <= vp_in;
               state_ff <= B_UPD;
            end
            B_UPD: begin
               st_ff    <= st_in;
               state_ff <= B_Y;
            end
            B_Y: begin
               y_ff     <= y_in;
               state_ff <= B_MULG;
            end
            B_MULG: begin
               pg_ff    <= pg_in;
               state_ff <= B_DIV1;
            end
            B_DIV1: begin
               u_ff     <= u_in;
               state_ff <= B_DIV2;
            end
            B_DIV2: begin
               pr_ff    <= pr_in;
               state_ff <= B_DIV3;
            end
            B_DIV3: begin
               if (out_free) begin
                  out_ff   <= out_in;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// File: dv/fmsam_checker.sv
// Output pair predictor and comparator for the FM stereo audio matrix.
`timescale 1ns / 100ps
module fmsam_audio_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   input  logic [31:0]                            req_tdata,   // sum_sample, diff_sample
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [31:0]                            rsp_tdata,   // left_out, right_out
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [fmsam_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fmsam_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output int                                     mismatch_total,
   output int                                     pairs_pending,
   output int                                     pairs_checked
);
   import fmsam_pkg::*;

   localparam int     SW          = SAMPLE_WIDTH_DEF;
   localparam int     FB          = DEEMPH_FRAC_BITS_DEF;
   localparam longint SAMPLE_MAX  = (longint'(1) << (SW - 1)) - 1;
   localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
   localparam longint LP_SCALE    = longint'(1) << FB;
   localparam longint LP_HALF     = LP_SCALE >> 1;
   // Q4.12 volume times a percentage, so the divisor is 4096 * 100.
   localparam longint VOL_DIV     = 409600;
   localparam longint VOL_ROUND   = VOL_DIV / 2;
   localparam int     REPORT_MAX  = 10;

   typedef struct packed {
      logic signed [SW-1:0] right_out;
      logic signed [SW-1:0] left_out;
   } audio_pair_type;

   audio_pair_type          expected_pairs[$];
   logic                    cfg_pano;
   logic [2:0]              cfg_select;
   longint                  cfg_pan_gain;
   longint                  cfg_alpha;
   longint                  cfg_volume;
   longint                  cfg_balance;
   logic signed [SW+FB-1:0] lp_left;
   logic signed [SW+FB-1:0] lp_right;
   int                      mismatches;
   int                      checked_count;

   function automatic longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp_sample(longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // One-pole de-emphasis update; the state wraps at its own width.
   function automatic logic signed [SW+FB-1:0] lowpass_step(longint state, longint x);
      longint err;
      err = x * LP_SCALE - state;
      return (SW+FB)'(state + floor_div(err * cfg_alpha + 32768, 65536));
   endfunction

   function automatic longint lowpass_out(longint state);
      return clamp_sample(floor_div(state + LP_HALF, LP_SCALE));
   endfunction

   function automatic longint apply_volume(longint y, longint pct);
      return clamp_sample(floor_div(y * cfg_volume * pct + VOL_ROUND, VOL_DIV));
   endfunction

   function automatic audio_pair_type predict_pair(longint sum_in, longint diff_in);
      longint         diff_w, left_m, right_m, ch_a, ch_b, bal, pct_l, pct_r;
      audio_pair_type r;
      diff_w = diff_in;
      if (cfg_pano) diff_w = clamp_sample(floor_div(diff_in * cfg_pan_gain + 128, 256));
      left_m  = clamp_sample(sum_in + diff_w);
      right_m = clamp_sample(sum_in - diff_w);
      case (cfg_select)
         SEL_SWAPPED: begin
            ch_a = right_m;
            ch_b = left_m;
         end
         SEL_LEFT: begin
            ch_a = left_m;
            ch_b = left_m;
         end
         SEL_RIGHT: begin
            ch_a = right_m;
            ch_b = right_m;
         end
         SEL_SUM: begin
            ch_a = sum_in;
            ch_b = sum_in;
         end
         SEL_DIFF, SEL_DIFF_TEST: begin
            ch_a = diff_w;
            ch_b = diff_w;
         end
         default: begin
            ch_a = left_m;
            ch_b = right_m;
         end
      endcase
      lp_left  = lowpass_step(lp_left, ch_a);
      lp_right = lowpass_step(lp_right, ch_b);
      bal = cfg_balance;
      if (bal > 100) bal = 100;
      if (bal < -100) bal = -100;
      pct_l = (bal > 0) ? 100 - bal : 100;
      pct_r = (bal < 0) ? 100 + bal : 100;
      r.left_out  = SW'(apply_volume(lowpass_out(lp_left), pct_l));
      r.right_out = SW'(apply_volume(lowpass_out(lp_right), pct_r));
      return r;
   endfunction

   always @(posedge clock) begin
      audio_pair_type got;
      audio_pair_type want;
      audio_pair_type next_pair;
      logic           left_bad;
      logic           right_bad;
      if (reset) begin
         cfg_pano      = 1'b0;
         cfg_pan_gain  = 256;
         cfg_select    = SEL_STEREO;
         cfg_alpha     = 6827;
         cfg_volume    = 2048;
         cfg_balance   = 0;
         lp_left       = '0;
         lp_right      = '0;
         mismatches    = 0;
         checked_count = 0;
         expected_pairs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PANO_ENABLE:   cfg_pano     = csr_data[0];
               CSR_PANORAMA_GAIN: cfg_pan_gain = longint'(csr_data[9:0]);
               CSR_OUTPUT_SELECT: cfg_select   = csr_data[2:0];
               CSR_DEEMPH_ALPHA:  cfg_alpha    = longint'(csr_data);
               CSR_VOLUME_GAIN:   cfg_volume   = longint'(csr_data);
               CSR_BALANCE:       cfg_balance  = longint'($signed(csr_data[7:0]));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[2*SW-1:0];
            if (expected_pairs.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected output pair: left %0d right %0d",
                           got.left_out, got.right_out);
            end else begin
               want = expected_pairs.pop_front();
               checked_count++;
               left_bad  = (got.left_out !== want.left_out);
               right_bad = (got.right_out !== want.right_out);
               if (left_bad || right_bad) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     if (left_bad)
                        $display("pair %0d left_out: expected %0d, got %0d",
                                 checked_count, want.left_out, got.left_out);
                     if (right_bad)
                        $display("pair %0d right_out: expected %0d, got %0d",
                                 checked_count, want.right_out, got.right_out);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            next_pair = predict_pair(longint'($signed(req_tdata[SW-1:0])),
                                     longint'($signed(req_tdata[2*SW-1:SW])));
            expected_pairs = {expected_pairs, next_pair};
         end
      end
      mismatch_total <= mismatches;
      pairs_checked  <= checked_count;
      pairs_pending  <= expected_pairs.size();
   end

endmodule

// File: dv/tb.sv
// Top-level testbench for the FM stereo audio matrix: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
   import fmsam_pkg::*;

   localparam int CYCLE_LIMIT       = 400000;
   localparam int SETTLE_CYCLES     = 16;
   localparam int RANDOM_PHASES     = 12;
   localparam int SAMPLES_PER_PHASE = 82;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [2:0]                 SEL_SPARE    = 3'd7;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [31:0]                 req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [31:0]                 rsp_tdata;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_data;

   bit  idling_on;
   int  samples_sent;
   int  csr_writes;
   int  settings_applied;
   int  cycle_count;
   int  chk_errors;
   int  chk_pending;
   int  chk_checked;

   logic [2:0] sel_codes[8] = '{SEL_STEREO, SEL_SWAPPED, SEL_LEFT, SEL_RIGHT,
                                SEL_SUM, SEL_DIFF, SEL_DIFF_TEST, SEL_SPARE};

   fm_stereo_audio_matrix_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   fmsam_audio_checker pair_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_total (chk_errors),
      .pairs_pending  (chk_pending),
      .pairs_checked  (chk_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The output side stalls in bursts while idling is on.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         1: return 16'($urandom_range(0, 511)) - 16'd256;
         default: return 16'($urandom);
      endcase
   endfunction

   // Leaves req_tvalid high after the transfer so that back-to-back samples need no gap.
   task automatic send_sample(input logic [15:0] sum_s, input logic [15:0] diff_s);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {diff_s, sum_s};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Holds the sender off until every expected pair has been seen, then lets the block settle.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (chk_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_random_setting();
      logic [15:0] junk;
      logic [9:0]  gain;
      logic [15:0] alpha;
      logic [15:0] vol;
      logic [7:0]  bal;
      junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
      case ($urandom_range(0, 4))
         0: gain = 10'd0;
         1: gain = 10'd256;
         2: gain = 10'd512;
         3: gain = 10'd1023;
         default: gain = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 4))
         0: alpha = 16'd0;
         1: alpha = 16'hFFFF;
         2: alpha = 16'd6827;
         3: alpha = 16'd1;
         default: alpha = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: vol = 16'd0;
         1: vol = 16'hFFFF;
         2: vol = 16'd4096;
         default: vol = 16'($urandom);
      endcase
      case ($urandom_range(0, 6))
         0: bal = 8'h80;
         1: bal = 8'h7F;
         2: bal = 8'd100;
         3: bal = 8'(-100);
         4: bal = 8'd0;
         default: bal = 8'($urandom);
      endcase
      write_reg(CSR_PANO_ENABLE, {junk[15:1], 1'($urandom)});
      write_reg(CSR_PANORAMA_GAIN, {junk[15:10], gain});
      write_reg(CSR_OUTPUT_SELECT, {junk[15:3], sel_codes[$urandom_range(0, 7)]});
      write_reg(CSR_DEEMPH_ALPHA, alpha);
      write_reg(CSR_VOLUME_GAIN, vol);
      write_reg(CSR_BALANCE, {junk[15:8], bal});
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, 16'($urandom));
      end_writes();
   endtask

   initial begin
      int ph;
      int k;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      idling_on        = 1'b1;
      samples_sent     = 0;
      csr_writes       = 0;
      settings_applied = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Register defaults with full-scale inputs.
      send_sample(16'h0000, 16'h0000);
      send_sample(16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h8000);
      send_sample(16'h8000, 16'h7FFF);
      send_sample(16'hFFFF, 16'h0001);

      // Saturating panorama weight, fastest filter, loudest volume and out-of-range
      // balance, stepped through every output selection including the unused code.
      drain_block();
      write_reg(CSR_PANO_ENABLE, 16'h0001);
      write_reg(CSR_PANORAMA_GAIN, 16'd1023);
      write_reg(CSR_DEEMPH_ALPHA, 16'hFFFF);
      write_reg(CSR_VOLUME_GAIN, 16'hFFFF);
      write_reg(CSR_BALANCE, 16'h007F);
      end_writes();
      for (k = 0; k < 8; k++) begin
         drain_block();
         write_reg(CSR_OUTPUT_SELECT, {13'd0, sel_codes[k]});
         end_writes();
         send_sample(16'h7FFF, 16'h8000);
         send_sample(16'h8000, 16'h7FFF);
      end

      // A frozen filter, right channel muted by negative overrange balance,
      // and writes to indexes that hold no register.
      drain_block();
      write_reg(CSR_DEEMPH_ALPHA, 16'h0000);
      write_reg(CSR_VOLUME_GAIN, 16'd4096);
      write_reg(CSR_BALANCE, 16'h0080);
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'hFFFF);
      end_writes();
      send_sample(16'd12345, 16'(-2345));
      send_sample(16'h8000, 16'h8000);

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_block();
         if (ph == RANDOM_PHASES - 1) idling_on = 1'b0;
         program_random_setting();
         for (k = 0; k < SAMPLES_PER_PHASE; k++)
            send_sample(pick_sample(), pick_sample());
      end

      drain_block();
      $display("Covered %0d sum/difference samples under %0d register settings (%0d writes),",
               samples_sent, settings_applied, csr_writes);
      $display("%s %0d pairs compared.",
               "all output selections and saturating gain, filter and balance cases;",
               chk_checked);
      if (chk_errors == 0 && chk_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
